### sv/bpc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
package bpc_pkg;

  localparam int unsigned TFINE_OFS = 128000;
  localparam logic [20:0] PRESS_BASE = 21'd1048576;
  localparam logic [11:0] PRESS_SCALE = 12'd3125;
  localparam logic [63:0] DEN_BIAS = 64'h0000_8000_0000_0000;
  localparam int unsigned DIV_STAGES = 32;

  typedef enum logic [1:0] {
    REG_TEMP_COEFFS  = 2'd0,
    REG_PRESS_A      = 2'd1,
    REG_PRESS_B      = 2'd2,
    REG_PRESS_NINE   = 2'd3
  } bpc_reg_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } bpc_coef_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] num;
    logic [30:0] den;
    logic [15:0] temp;
  } bpc_div_in_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] quo;
    logic        nz;
    logic [15:0] temp;
  } bpc_div_out_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] temp;
    logic [31:0] press;
    logic        pvalid;
  } bpc_res_t;

endpackage

### sv/bpc_if.sv
// Channel interfaces: sample input, result output and register write port.
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  modport source(output valid, raw_temperature, raw_pressure, input ready);
  modport sink(input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_centi;
  logic        [31:0] pressure_q24_8;
  logic               pressure_valid;
  modport source(output valid, temperature_centi, pressure_q24_8, pressure_valid,
                 input ready);
  modport sink(input valid, temperature_centi, pressure_q24_8, pressure_valid,
               output ready);
endinterface

interface bpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### sv/bpc_front.sv
// Front pipeline: fine temperature, temperature result, divisor and dividend.
module bpc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [19:0]           raw_t,
  input  logic [19:0]           raw_p,
  input  bpc_pkg::bpc_coef_t    coef,
  output bpc_pkg::bpc_div_in_t  div_o
);

  logic        [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;
  assign t1 = coef.t1;
  assign t2 = coef.t2;
  assign t3 = coef.t3;
  assign p1 = coef.p1;
  assign p2 = coef.p2;
  assign p3 = coef.p3;
  assign p4 = coef.p4;
  assign p5 = coef.p5;
  assign p6 = coef.p6;

  logic [9:1] v_r;

  // Stage 1 products.
  logic signed [17:0] ta;
  logic signed [16:0] td;
  logic signed [33:0] ta_m, td_m;
  assign ta   = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign td   = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, t1});
  assign ta_m = ta * t2;
  assign td_m = td * td;

  logic signed [20:0] s1_tv1_r;
  logic signed [19:0] s1_dd_r;
  logic        [19:0] s1_rp_r, s2_rp_r, s3_rp_r, s4_rp_r, s5_rp_r, s6_rp_r;

  // Stage 2: fine temperature.
  logic signed [35:0] tv2_m;
  logic signed [17:0] tv2;
  logic        [21:0] tf_nxt;
  assign tv2_m  = s1_dd_r * t3;
  assign tv2    = tv2_m[31:14];
  assign tf_nxt = {s1_tv1_r[20], s1_tv1_r} + {{4{tv2[17]}}, tv2};

  logic signed [21:0] s2_tf_r;

  // Stage 3: temperature result and pressure offset.
  logic [24:0] t5;
  logic [16:0] tcv;
  logic [15:0] temp_nxt;
  logic [22:0] pv1_nxt;
  assign t5  = {{3{s2_tf_r[21]}}, s2_tf_r} + {s2_tf_r[21], s2_tf_r, 2'b00} + 25'd128;
  assign tcv = t5[24:8];
  assign temp_nxt = (tcv[16] != tcv[15]) ? (tcv[16] ? 16'h8000 : 16'h7fff) : tcv[15:0];
  assign pv1_nxt  = {s2_tf_r[21], s2_tf_r} - 23'(bpc_pkg::TFINE_OFS);

  logic signed [22:0] s3_pv1_r;
  logic        [15:0] s3_temp_r, s4_temp_r, s5_temp_r, s6_temp_r, s7_temp_r,
                      s8_temp_r, s9_temp_r;

  // Stage 4 products.
  logic signed [45:0] sq_nxt;
  logic signed [38:0] m5_nxt, m2_nxt;
  assign sq_nxt = s3_pv1_r * s3_pv1_r;
  assign m5_nxt = s3_pv1_r * p5;
  assign m2_nxt = s3_pv1_r * p2;

  logic signed [45:0] s4_sq_r;
  logic signed [38:0] s4_m5_r, s4_m2_r, s5_m5_r, s5_m2_r;

  // Stage 5 products.
  logic signed [61:0] sq6_nxt, sq3_nxt;
  assign sq6_nxt = s4_sq_r * p6;
  assign sq3_nxt = s4_sq_r * p3;

  logic signed [61:0] s5_sq6_r, s5_sq3_r;

  // Stage 6 sums, wrapping at 64 bits.
  logic [63:0] v2_nxt, v1b_nxt;
  assign v2_nxt  = {{2{s5_sq6_r[61]}}, s5_sq6_r} + {{8{s5_m5_r[38]}}, s5_m5_r, 17'b0}
                 + {{13{p4[15]}}, p4, 35'b0};
  assign v1b_nxt = {{10{s5_sq3_r[61]}}, s5_sq3_r[61:8]}
                 + {{13{s5_m2_r[38]}}, s5_m2_r, 12'b0};

  logic [63:0] s6_v2_r, s6_v1b_r;

  // Stage 7: operands for the split multiplications.
  logic [20:0] prp;
  logic [63:0] x_nxt, n_nxt;
  assign prp   = bpc_pkg::PRESS_BASE - {1'b0, s6_rp_r};
  assign x_nxt = bpc_pkg::DEN_BIAS + s6_v1b_r;
  assign n_nxt = {12'b0, prp, 31'b0} - s6_v2_r;

  logic [63:0] s7_x_r, s7_n_r;

  // Stage 8: 32-bit partial products; only the low word of the high half matters.
  logic [47:0] xl_nxt;
  logic [31:0] xh_nxt, nh_nxt;
  logic [43:0] nl_nxt;
  assign xl_nxt = s7_x_r[31:0] * p1;
  assign xh_nxt = s7_x_r[63:32] * 32'(p1);
  assign nl_nxt = s7_n_r[31:0] * bpc_pkg::PRESS_SCALE;
  assign nh_nxt = s7_n_r[63:32] * 32'(bpc_pkg::PRESS_SCALE);

  logic [47:0] s8_xl_r;
  logic [31:0] s8_xh_r, s8_nh_r;
  logic [43:0] s8_nl_r;

  // Stage 9: recombine.
  logic [63:0] prod, num_nxt;
  assign prod    = {16'b0, s8_xl_r} + {s8_xh_r, 32'b0};
  assign num_nxt = {20'b0, s8_nl_r} + {s8_nh_r, 32'b0};

  logic [63:0] s9_num_r;
  logic [30:0] s9_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[8:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tv1_r  <= ta_m[31:11];
      s1_dd_r   <= td_m[31:12];
      s1_rp_r   <= raw_p;
      s2_tf_r   <= $signed(tf_nxt);
      s2_rp_r   <= s1_rp_r;
      s3_pv1_r  <= $signed(pv1_nxt);
      s3_temp_r <= temp_nxt;
      s3_rp_r   <= s2_rp_r;
      s4_sq_r   <= sq_nxt;
      s4_m5_r   <= m5_nxt;
      s4_m2_r   <= m2_nxt;
      s4_temp_r <= s3_temp_r;
      s4_rp_r   <= s3_rp_r;
      s5_sq6_r  <= sq6_nxt;
      s5_sq3_r  <= sq3_nxt;
      s5_m5_r   <= s4_m5_r;
      s5_m2_r   <= s4_m2_r;
      s5_temp_r <= s4_temp_r;
      s5_rp_r   <= s4_rp_r;
      s6_v2_r   <= v2_nxt;
      s6_v1b_r  <= v1b_nxt;
      s6_temp_r <= s5_temp_r;
      s6_rp_r   <= s5_rp_r;
      s7_x_r    <= x_nxt;
      s7_n_r    <= n_nxt;
      s7_temp_r <= s6_temp_r;
      s8_xl_r   <= xl_nxt;
      s8_xh_r   <= xh_nxt;
      s8_nl_r   <= nl_nxt;
      s8_nh_r   <= nh_nxt;
      s8_temp_r <= s7_temp_r;
      s9_num_r  <= num_nxt;
      s9_den_r  <= prod[63:33];
      s9_temp_r <= s8_temp_r;
    end
  end

  assign div_o.valid = v_r[9];
  assign div_o.num   = s9_num_r;
  assign div_o.den   = s9_den_r;
  assign div_o.temp  = s9_temp_r;

endmodule

### sv/bpc_div.sv
// Pipelined signed 64-by-31-bit divider, two quotient bits per stage.
module bpc_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  bpc_pkg::bpc_div_in_t   div_i,
  output bpc_pkg::bpc_div_out_t  div_o
);

  typedef struct packed {
    logic        valid;
    logic [63:0] dq;
    logic [31:0] rem;
    logic [30:0] dv;
    logic        neg;
    logic        nz;
    logic [15:0] temp;
  } div_stg_t;

  function automatic div_stg_t div_bit(input div_stg_t s);
    div_stg_t    o;
    logic [31:0] r2;
    logic        ge;
    o  = s;
    r2 = {s.rem[30:0], s.dq[63]};
    ge = (r2 >= {1'b0, s.dv});
    o.rem = ge ? (r2 - {1'b0, s.dv}) : r2;
    o.dq  = {s.dq[62:0], ge};
    return o;
  endfunction

  div_stg_t stg_r [0:bpc_pkg::DIV_STAGES];
  div_stg_t stg0_nxt;
  bpc_pkg::bpc_div_out_t out_r;

  // Work on magnitudes; the sign is restored after the last stage.
  always_comb begin
    stg0_nxt.valid = div_i.valid;
    stg0_nxt.dq    = div_i.num[63] ? (64'd0 - div_i.num) : div_i.num;
    stg0_nxt.rem   = '0;
    stg0_nxt.dv    = div_i.den[30] ? (31'd0 - div_i.den) : div_i.den;
    stg0_nxt.neg   = div_i.num[63] ^ div_i.den[30];
    stg0_nxt.nz    = (div_i.den != '0);
    stg0_nxt.temp  = div_i.temp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r[0].valid <= 1'b0;
    end else if (adv) begin
      stg_r[0] <= stg0_nxt;
    end
  end

  for (genvar i = 1; i <= bpc_pkg::DIV_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[i].valid <= 1'b0;
      end else if (adv) begin
        stg_r[i] <= div_bit(div_bit(stg_r[i-1]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (adv) begin
      out_r.valid <= stg_r[bpc_pkg::DIV_STAGES].valid;
      out_r.quo   <= stg_r[bpc_pkg::DIV_STAGES].neg ?
                     (64'd0 - stg_r[bpc_pkg::DIV_STAGES].dq) :
                     stg_r[bpc_pkg::DIV_STAGES].dq;
      out_r.nz    <= stg_r[bpc_pkg::DIV_STAGES].nz;
      out_r.temp  <= stg_r[bpc_pkg::DIV_STAGES].temp;
    end
  end

  assign div_o = out_r;

  // For a nonzero divisor, the partial remainder stays below the divisor magnitude.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stg_r[bpc_pkg::DIV_STAGES].valid && stg_r[bpc_pkg::DIV_STAGES].nz |->
    stg_r[bpc_pkg::DIV_STAGES].rem < {1'b0, stg_r[bpc_pkg::DIV_STAGES].dv})
    else $error("divider remainder exceeds divisor");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    adv && stg_r[0].valid |=> stg_r[1].valid)
    else $error("divider lost a beat between stages");

endmodule

### sv/bpc_back.sv
// Back pipeline: second-order pressure correction, offset and saturation.
module bpc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  bpc_pkg::bpc_div_out_t  div_i,
  input  bpc_pkg::bpc_coef_t     coef,
  output bpc_pkg::bpc_res_t      res_o
);

  logic signed [15:0] p7, p8, p9;
  assign p7 = coef.p7;
  assign p8 = coef.p8;
  assign p9 = coef.p9;

  logic [5:1]  v_r;
  logic [5:1]  nz_r;
  logic [15:0] temp1_r, temp2_r, temp3_r, temp4_r, temp5_r;

  // Stage 1: s = p >>> 13, then split products by P9 and P8.
  logic [63:0]        s;
  logic signed [48:0] a0_nxt, b0_nxt;
  logic [31:0]        a1_nxt, b1_nxt;
  assign s      = {{13{div_i.quo[63]}}, div_i.quo[63:13]};
  assign a0_nxt = $signed({1'b0, s[31:0]}) * p9;
  assign a1_nxt = s[63:32] * {{16{p9[15]}}, p9};
  assign b0_nxt = $signed({1'b0, div_i.quo[31:0]}) * p8;
  assign b1_nxt = div_i.quo[63:32] * {{16{p8[15]}}, p8};

  logic signed [48:0] q1_a0_r, q1_b0_r;
  logic [31:0]        q1_a1_r, q1_b1_r;
  logic [63:0]        q1_s_r, q1_q_r;

  // Stage 2: recombine; w2 = (p * P8) >>> 19.
  logic [63:0] u_nxt, w2f;
  assign u_nxt = {{15{q1_a0_r[48]}}, q1_a0_r} + {q1_a1_r, 32'b0};
  assign w2f   = {{15{q1_b0_r[48]}}, q1_b0_r} + {q1_b1_r, 32'b0};

  logic [63:0] q2_u_r, q2_s_r, q2_q_r, q2_w2_r;

  // Stage 3: (u * s) mod 2^64 from three 32-bit products.
  logic [63:0] m0_nxt;
  logic [31:0] m1_nxt, m2_nxt;
  assign m0_nxt = q2_u_r[31:0] * q2_s_r[31:0];
  assign m1_nxt = q2_u_r[63:32] * q2_s_r[31:0];
  assign m2_nxt = q2_u_r[31:0] * q2_s_r[63:32];

  logic [63:0] q3_m0_r, q3_q_r, q3_w2_r, q4_q_r, q4_w2_r;
  logic [31:0] q3_m1_r, q3_m2_r;

  // Stage 4: w1.
  logic [63:0] w1f;
  logic [31:0] mh;
  assign mh  = q3_m1_r + q3_m2_r;
  assign w1f = q3_m0_r + {mh, 32'b0};

  logic [63:0] q4_w1_r;

  // Stage 5: final sum and P7 offset.
  logic [63:0] sum3, r_nxt;
  assign sum3  = q4_q_r + q4_w1_r + q4_w2_r;
  assign r_nxt = {{8{sum3[63]}}, sum3[63:8]} + {{44{p7[15]}}, p7, 4'b0};

  logic [63:0] q5_r_r;

  // Stage 6: saturation, or zero without a divisor, into the output register.
  logic [31:0] press_nxt;
  always_comb begin
    priority if (!nz_r[5]) begin
      press_nxt = '0;
    end else if (q5_r_r[63]) begin
      press_nxt = '0;
    end else if (q5_r_r[62:32] != '0) begin
      press_nxt = '1;
    end else begin
      press_nxt = q5_r_r[31:0];
    end
  end

  bpc_pkg::bpc_res_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_r.valid <= 1'b0;
    end else if (adv) begin
      v_r          <= {v_r[4:1], div_i.valid};
      out_r.valid  <= v_r[5];
      out_r.temp   <= temp5_r;
      out_r.press  <= press_nxt;
      out_r.pvalid <= nz_r[5];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nz_r         <= {nz_r[4:1], div_i.nz};
      temp1_r      <= div_i.temp;
      temp2_r      <= temp1_r;
      temp3_r      <= temp2_r;
      temp4_r      <= temp3_r;
      temp5_r      <= temp4_r;
      q1_a0_r      <= a0_nxt;
      q1_a1_r      <= a1_nxt;
      q1_b0_r      <= b0_nxt;
      q1_b1_r      <= b1_nxt;
      q1_s_r       <= s;
      q1_q_r       <= div_i.quo;
      q2_u_r       <= u_nxt;
      q2_s_r       <= q1_s_r;
      q2_q_r       <= q1_q_r;
      q2_w2_r      <= {{19{w2f[63]}}, w2f[63:19]};
      q3_m0_r      <= m0_nxt;
      q3_m1_r      <= m1_nxt;
      q3_m2_r      <= m2_nxt;
      q3_q_r       <= q2_q_r;
      q3_w2_r      <= q2_w2_r;
      q4_w1_r      <= {{25{w1f[63]}}, w1f[63:25]};
      q4_q_r       <= q3_q_r;
      q4_w2_r      <= q3_w2_r;
      q5_r_r       <= r_nxt;
    end
  end

  assign res_o = out_r;

endmodule

### sv/baro_temp_pressure_compensation_unit.sv
// Top level: calibration registers, pipeline sections and result handshake.
// Throughput: one sample pair per cycle while the output is not stalled; the 32-stage divider is the deepest section.
// A stalled output freezes every stage at once, so no beat is lost or repeated.
// Synchronous active-low reset clears all valid bits and the calibration registers.
module baro_temp_pressure_compensation_unit (
  input  logic       clk,
  input  logic       rst_n,
  bpc_in_if.sink     in_ch,
  bpc_out_if.source  out_ch,
  bpc_cfg_if.sink    cfg_ch
);

  logic [47:0] temp_coeffs_r;
  logic [63:0] press_a_r, press_b_r;
  logic [15:0] press_nine_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_a_r     <= '0;
      press_b_r     <= '0;
      press_nine_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (bpc_pkg::bpc_reg_t'(cfg_ch.index))
        bpc_pkg::REG_TEMP_COEFFS: temp_coeffs_r <= cfg_ch.data[47:0];
        bpc_pkg::REG_PRESS_A:     press_a_r     <= cfg_ch.data;
        bpc_pkg::REG_PRESS_B:     press_b_r     <= cfg_ch.data;
        bpc_pkg::REG_PRESS_NINE:  press_nine_r  <= cfg_ch.data[15:0];
      endcase
    end
  end

  bpc_pkg::bpc_coef_t coef;
  assign coef.t1 = temp_coeffs_r[15:0];
  assign coef.t2 = temp_coeffs_r[31:16];
  assign coef.t3 = temp_coeffs_r[47:32];
  assign coef.p1 = press_a_r[15:0];
  assign coef.p2 = press_a_r[31:16];
  assign coef.p3 = press_a_r[47:32];
  assign coef.p4 = press_a_r[63:48];
  assign coef.p5 = press_b_r[15:0];
  assign coef.p6 = press_b_r[31:16];
  assign coef.p7 = press_b_r[47:32];
  assign coef.p8 = press_b_r[63:48];
  assign coef.p9 = press_nine_r;

  bpc_pkg::bpc_div_in_t  div_in;
  bpc_pkg::bpc_div_out_t div_out;
  bpc_pkg::bpc_res_t     res;
  logic                  adv;

  // The whole pipeline moves whenever the output register is free or drained.
  assign adv         = !res.valid || out_ch.ready;
  assign in_ch.ready = adv;

  bpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .raw_t    (in_ch.raw_temperature),
    .raw_p    (in_ch.raw_pressure),
    .coef     (coef),
    .div_o    (div_in)
  );

  bpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .div_i (div_in),
    .div_o (div_out)
  );

  bpc_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .div_i (div_out),
    .coef  (coef),
    .res_o (res)
  );

  assign out_ch.valid             = res.valid;
  assign out_ch.temperature_centi = $signed(res.temp);
  assign out_ch.pressure_q24_8    = res.press;
  assign out_ch.pressure_valid    = res.pvalid;

  a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.pressure_valid |-> out_ch.pressure_q24_8 == '0)
    else $error("pressure nonzero with zero divisor");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline is stalled");

endmodule

### tb/tb_baro_temp_pressure_compensation_unit.sv
// Self-checking testbench for the barometric temperature and pressure compensation unit.
module tb_baro_temp_pressure_compensation_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
  } sample_t;

  typedef struct {
    logic signed [15:0] temp;
    logic        [31:0] press;
    logic               pvalid;
  } comp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bpc_in_if  in_if();
  bpc_out_if out_if();
  bpc_cfg_if cfg_if();

  baro_temp_pressure_compensation_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source),
    .cfg_ch (cfg_if.sink)
  );

  always #5 clk = ~clk;

  // Calibration registers as the block should hold them.
  logic [47:0] cal_temp;
  logic [63:0] cal_press_a;
  logic [63:0] cal_press_b;
  logic [15:0] cal_press_nine;

  sample_t      pending_samples[$];
  comp_result_t expected_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off = 1'b0;
  int unsigned fail_count = 0;
  int unsigned result_count = 0;
  int unsigned no_divisor_count = 0;
  int unsigned clamp_count = 0;

  function automatic comp_result_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
    logic signed [31:0] t1, t2, t3, a, d, v1, v2, prod, t_fine, tcv;
    logic signed [63:0] c1, c2, c3, c4, c5, c6, c7, c8, c9;
    logic signed [63:0] x1, x2, pp, num, w1, w2, bias;
    comp_result_t r;
    t1 = {16'd0, cal_temp[15:0]};
    t2 = $signed(cal_temp[31:16]);
    t3 = $signed(cal_temp[47:32]);
    a = ({12'd0, raw_t} >> 3) - (t1 <<< 1);
    prod = a * t2;
    v1 = prod >>> 11;
    d = ({12'd0, raw_t} >> 4) - t1;
    prod = d * d;
    prod = prod >>> 12;
    prod = prod * t3;
    v2 = prod >>> 14;
    t_fine = v1 + v2;
    prod = t_fine * 5 + 128;
    tcv = prod >>> 8;
    if (tcv < -32768) r.temp = 16'h8000;
    else if (tcv > 32767) r.temp = 16'h7fff;
    else r.temp = tcv[15:0];

    c1 = {48'd0, cal_press_a[15:0]};
    c2 = $signed(cal_press_a[31:16]);
    c3 = $signed(cal_press_a[47:32]);
    c4 = $signed(cal_press_a[63:48]);
    c5 = $signed(cal_press_b[15:0]);
    c6 = $signed(cal_press_b[31:16]);
    c7 = $signed(cal_press_b[47:32]);
    c8 = $signed(cal_press_b[63:48]);
    c9 = $signed(cal_press_nine);
    bias = 64'h0000_8000_0000_0000;
    x1 = t_fine;
    x1 = x1 - 64'sd128000;
    x2 = x1 * x1 * c6;
    x2 = x2 + ((x1 * c5) <<< 17);
    x2 = x2 + (c4 <<< 35);
    x1 = ((x1 * x1 * c3) >>> 8) + ((x1 * c2) <<< 12);
    x1 = ((bias + x1) * c1) >>> 33;
    r.press = '0;
    r.pvalid = 1'b0;
    if (x1 != 0) begin
      pp = 64'sd1048576 - $signed({44'd0, raw_p});
      num = ((pp <<< 31) - x2) * 64'sd3125;
      // The most negative numerator over minus one wraps back onto itself.
      if (num == 64'sh8000_0000_0000_0000 && x1 == -64'sd1) pp = num;
      else pp = num / x1;
      w1 = (c9 * (pp >>> 13) * (pp >>> 13)) >>> 25;
      w2 = (c8 * pp) >>> 19;
      pp = ((pp + w1 + w2) >>> 8) + (c7 <<< 4);
      if (pp < 0) r.press = '0;
      else if (pp > 64'sd4294967295) r.press = 32'hffff_ffff;
      else r.press = pp[31:0];
      r.pvalid = 1'b1;
    end
    return r;
  endfunction

  // Sample driver: offers the oldest pending sample unless this cycle idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(compensate(in_if.raw_temperature, in_if.raw_pressure));
        void'(pending_samples.pop_front());
      end
      if (in_if.valid && !in_if.ready) begin
        // A beat on offer stays unchanged until the block takes it.
        in_if.valid <= 1'b1;
      end else if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid           <= 1'b1;
        in_if.raw_temperature <= pending_samples[0].raw_t;
        in_if.raw_pressure    <= pending_samples[0].raw_p;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver backpressure.
  always @(posedge clk) begin
    comp_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no sample outstanding");
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        result_count++;
        if (!exp_r.pvalid) no_divisor_count++;
        if (exp_r.press == 32'hffff_ffff || exp_r.temp == 16'h7fff || exp_r.temp == 16'h8000)
          clamp_count++;
        if (out_if.temperature_centi !== exp_r.temp) begin
          $error("temperature_centi expected %0d got %0d", exp_r.temp,
                 out_if.temperature_centi);
          fail_count++;
        end
        if (out_if.pressure_q24_8 !== exp_r.press) begin
          $error("pressure_q24_8 expected %0h got %0h", exp_r.press, out_if.pressure_q24_8);
          fail_count++;
        end
        if (out_if.pressure_valid !== exp_r.pvalid) begin
          $error("pressure_valid expected %0b got %0b", exp_r.pvalid, out_if.pressure_valid);
          fail_count++;
        end
      end
    end
    out_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(bpc_pkg::bpc_reg_t idx, logic [63:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      bpc_pkg::REG_TEMP_COEFFS: cal_temp       = value[47:0];
      bpc_pkg::REG_PRESS_A:     cal_press_a    = value;
      bpc_pkg::REG_PRESS_B:     cal_press_b    = value;
      bpc_pkg::REG_PRESS_NINE:  cal_press_nine = value[15:0];
    endcase
  endtask

  // Upper bits of the narrow registers carry noise; the block must drop them.
  task automatic load_calibration(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                                  logic [15:0] p9);
    write_reg(bpc_pkg::REG_TEMP_COEFFS, {16'($urandom), tc});
    write_reg(bpc_pkg::REG_PRESS_A, pa);
    write_reg(bpc_pkg::REG_PRESS_B, pb);
    write_reg(bpc_pkg::REG_PRESS_NINE, {48'($urandom) << 16, 16'd0} | {48'd0, p9});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [63:0] jitter(logic [63:0] w);
    logic [63:0] r;
    for (int k = 0; k < 4; k++) r[16*k +: 16] = w[16*k +: 16] + 16'($urandom_range(128)) - 16'd64;
    return r;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    if ($urandom_range(99) < 60) begin
      s.raw_t = 20'($urandom_range(620000, 420000));
      s.raw_p = 20'($urandom_range(650000, 200000));
    end else begin
      s.raw_t = 20'($urandom);
      s.raw_p = 20'($urandom);
    end
    return s;
  endfunction

  localparam logic [47:0] TYP_TEMP  = {16'hfc18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_PRESS_A = {16'd2855, 16'd3024, 16'hd643, 16'd36477};
  localparam logic [63:0] TYP_PRESS_B = {16'hc6f8, 16'd15500, 16'hfff9, 16'd140};
  localparam logic [15:0] TYP_NINE  = 16'd6000;

  initial begin
    logic [19:0] edge_vals[4];
    int unsigned mode;
    edge_vals = '{20'd0, 20'hfffff, 20'd519888, 20'd415148};
    in_if.valid = 1'b0;
    in_if.raw_temperature = '0;
    in_if.raw_pressure = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = bpc_pkg::REG_TEMP_COEFFS;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    cal_temp = '0;
    cal_press_a = '0;
    cal_press_b = '0;
    cal_press_nine = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one sample with the registers at reset, which leaves no divisor.
    pending_samples.push_back('{20'd519888, 20'd415148});
    wait_drained();
    load_calibration(TYP_TEMP, TYP_PRESS_A, TYP_PRESS_B, TYP_NINE);
    foreach (edge_vals[i]) foreach (edge_vals[j]) pending_samples.push_back('{edge_vals[i], edge_vals[j]});
    wait_drained();
    // Zero P1 forces the divisor to zero while the temperature still comes out.
    load_calibration(TYP_TEMP, {TYP_PRESS_A[63:16], 16'd0}, TYP_PRESS_B, TYP_NINE);
    pending_samples.push_back('{20'd0, 20'hfffff});
    pending_samples.push_back('{20'd519888, 20'd415148});
    wait_drained();
    load_calibration('1, '1, '1, '1);
    pending_samples.push_back('{20'hfffff, 20'd0});
    pending_samples.push_back('{20'd0, 20'hfffff});
    wait_drained();
    load_calibration({16'h7fff, 16'h8000, 16'hffff}, {16'h7fff, 16'h8000, 16'h7fff, 16'hffff},
                     {16'h8000, 16'h7fff, 16'h8000, 16'h7fff}, 16'h8000);
    pending_samples.push_back('{20'hfffff, 20'hfffff});
    pending_samples.push_back('{20'd0, 20'd0});
    wait_drained();

    // Random phases, cycling through the idling modes and register settings.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 5)
        0: load_calibration(TYP_TEMP, TYP_PRESS_A, TYP_PRESS_B, TYP_NINE);
        1, 3: load_calibration(48'(jitter({16'd0, TYP_TEMP})), jitter(TYP_PRESS_A),
                               jitter(TYP_PRESS_B), 16'(jitter({48'd0, TYP_NINE})));
        2: load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                            {$urandom, $urandom}, 16'($urandom));
        default: load_calibration('0, '0, '0, '0);
      endcase
      mode = ph % 4;
      send_idle_pct  <= (mode == 1) ? 73 : (mode == 3) ? 38 : 0;
      recv_stall_pct <= (mode == 2) ? 73 : (mode == 3) ? 38 : 0;
      for (int n = 0; n < 100; n++) pending_samples.push_back(random_sample());
      if (ph == 4) begin
        // Long receiver hold-off while samples keep coming so the pipeline backs up.
        fork
          begin
            hold_off <= 1'b1;
            repeat (400) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      wait_drained();
    end

    $display("Covered %0d results over 14 register settings and four idling modes;",
             result_count);
    $display("%0d had no pressure divisor and %0d hit an output clamp.", no_divisor_count,
             clamp_count);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #3ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
sv/bpc_pkg.sv
sv/bpc_if.sv
sv/bpc_front.sv
sv/bpc_div.sv
sv/bpc_back.sv
sv/baro_temp_pressure_compensation_unit.sv
tb/tb_baro_temp_pressure_compensation_unit.sv
